// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet while rst_n is
// low unless the form is about reset itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define APF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define APF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/apf_pkg.sv =====
// ----------------------------------------------------------------------------
// apf_pkg
// Constants, command codes and small helpers shared by the articulation
// point finder and its checker.
// ----------------------------------------------------------------------------
package apf_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int ROW_W        = MAX_VERTICES;
  localparam int VCNT_W       = 5;
  localparam int OUT_W        = 16;

  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(16);

  typedef enum logic {
    CMD_WRITE_EDGE = 1'b0,
    CMD_COMPUTE    = 1'b1
  } cmd_t;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [VIDX_W-1:0] vidx_t;

  // Single-bit row with bit idx set.
  function automatic row_t vbit(input vidx_t idx);
    return row_t'(1) << idx;
  endfunction

  // Index of the lowest set bit; zero when the vector is empty.
  function automatic vidx_t lowest_index(input row_t vec);
    vidx_t idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = VIDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/apf_ram.sv =====
// ----------------------------------------------------------------------------
// apf_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module apf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/articulation_point_finder_top.sv =====
// ----------------------------------------------------------------------------
// articulation_point_finder_top
// Articulation points of a small undirected graph, found by removing each
// vertex in turn and counting the components that remain.
// ----------------------------------------------------------------------------
// Edge write word: busy through ST_WR_A, and through ST_WR_B as well unless
// it is a self loop. Compute word: each in-use vertex is removed in turn and the
// components left are walked through ST_FIND, ST_EXPAND and ST_ABSORB; the result
// strobe follows the last step, or comes at once when no vertex is in use. The
// walk is paced by the adjacency RAM read port, one row per ST_EXPAND/ST_ABSORB pair.
// Reset (rst_n low, synchronous) empties the graph and sets vertex_count to 16.
module articulation_point_finder_top
  import apf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Command channel
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [3:0]        in_vertex_a,
  input  logic [3:0]        in_vertex_b,
  input  logic              in_edge_present,
  // Result channel
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_articulation_mask,
  // Configuration
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data
);

  // The walk keeps a reached set and a set of pending vertices whose
  // adjacency rows still have to be folded in. A component is opened in
  // ST_FIND at the lowest unreached in-use vertex; ST_EXPAND pops a pending
  // vertex and reads its row, and ST_ABSORB merges that row in the next cycle.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_A,
    ST_WR_B,
    ST_FIND,
    ST_EXPAND,
    ST_ABSORB
  } state_t;

  // The tally only needs to tell one component from more than one, so it
  // saturates at two.
  localparam logic [1:0] TALLY_MULTI = 2'd2;

  state_t            state_r,     state_nxt;
  logic [VCNT_W-1:0] vcount_r,    vcount_nxt;
  row_t              in_use_r,    in_use_nxt;
  vidx_t             last_v_r,    last_v_nxt;
  vidx_t             cur_v_r,     cur_v_nxt;
  row_t              reached_r,   reached_nxt;
  row_t              pending_r,   pending_nxt;
  logic [1:0]        tally_r,     tally_nxt;
  row_t              mask_r,      mask_nxt;
  vidx_t             edge_a_r,    edge_a_nxt;
  vidx_t             edge_b_r,    edge_b_nxt;
  logic              edge_set_r,  edge_set_nxt;
  row_t              row_valid_r, row_valid_nxt;
  vidx_t             rd_row_r,    rd_row_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Adjacency RAM port signals
  logic  ram_we;
  vidx_t ram_waddr;
  row_t  ram_wdata;
  vidx_t ram_raddr;
  row_t  ram_rdata;

  logic              accept;
  logic [VCNT_W-1:0] n_eff;
  row_t              in_use_now;
  row_t              unreached;
  row_t              row_seen;
  row_t              row_new;
  row_t              edge_row;
  vidx_t             pick;

  // Rows never written hold no edges; the per-row valid bits stand in for
  // clearing the RAM after reset.
  apf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // A vertex count above the matrix size is treated as the full matrix.
  assign n_eff = (vcount_r > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcount_r;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      in_use_now[i] = (VCNT_W'(i) < n_eff);
    end
  end

  assign unreached = ~reached_r & in_use_r;

  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = cfg_wr_en ? cfg_wr_data : vcount_r;
    in_use_nxt    = in_use_r;
    last_v_nxt    = last_v_r;
    cur_v_nxt     = cur_v_r;
    reached_nxt   = reached_r;
    pending_nxt   = pending_r;
    tally_nxt     = tally_r;
    mask_nxt      = mask_r;
    edge_a_nxt    = edge_a_r;
    edge_b_nxt    = edge_b_r;
    edge_set_nxt  = edge_set_r;
    row_valid_nxt = row_valid_r;
    rd_row_nxt    = rd_row_r;
    out_valid_nxt = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = edge_a_r;
    ram_wdata = '0;
    ram_raddr = '0;

    row_seen = row_valid_r[rd_row_r] ? ram_rdata : '0;
    row_new  = row_seen & in_use_r & ~reached_r;
    edge_row = '0;
    pick     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_WRITE_EDGE) begin
            // Both endpoints are four bits wide, so they always lie inside
            // the matrix and every edge write is carried out.
            edge_a_nxt   = in_vertex_a;
            edge_b_nxt   = in_vertex_b;
            edge_set_nxt = in_edge_present;
            ram_raddr    = in_vertex_a;
            rd_row_nxt   = in_vertex_a;
            state_nxt    = ST_WR_A;
          end else begin
            in_use_nxt = in_use_now;
            last_v_nxt = VIDX_W'(n_eff - VCNT_W'(1));
            mask_nxt   = '0;
            if (n_eff == '0) begin
              // No vertex in use: the mask is empty straight away.
              out_valid_nxt = 1'b1;
            end else begin
              cur_v_nxt   = '0;
              reached_nxt = vbit('0);
              tally_nxt   = '0;
              state_nxt   = ST_FIND;
            end
          end
        end
      end

      ST_WR_A: begin
        edge_row           = row_seen;
        edge_row[edge_b_r] = edge_set_r;
        ram_we             = 1'b1;
        ram_waddr          = edge_a_r;
        ram_wdata          = edge_row;
        row_valid_nxt[edge_a_r] = 1'b1;
        // The second row is read while the first is written; they differ,
        // since a self loop finishes here.
        ram_raddr  = edge_b_r;
        rd_row_nxt = edge_b_r;
        state_nxt  = (edge_a_r == edge_b_r) ? ST_IDLE : ST_WR_B;
      end

      ST_WR_B: begin
        edge_row           = row_seen;
        edge_row[edge_a_r] = edge_set_r;
        ram_we             = 1'b1;
        ram_waddr          = edge_b_r;
        ram_wdata          = edge_row;
        row_valid_nxt[edge_b_r] = 1'b1;
        state_nxt          = ST_IDLE;
      end

      ST_FIND: begin
        if (unreached == '0) begin
          // Every remaining vertex is placed: settle the removed vertex.
          mask_nxt[cur_v_r] = (tally_r == TALLY_MULTI);
          if (cur_v_r == last_v_r) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cur_v_nxt   = cur_v_r + VIDX_W'(1);
            reached_nxt = vbit(cur_v_r + VIDX_W'(1));
            tally_nxt   = '0;
          end
        end else begin
          // Open a new component at the lowest unreached vertex.
          pick        = lowest_index(unreached);
          tally_nxt   = (tally_r == TALLY_MULTI) ? tally_r : tally_r + 2'd1;
          reached_nxt = reached_r | vbit(pick);
          pending_nxt = vbit(pick);
          state_nxt   = ST_EXPAND;
        end
      end

      ST_EXPAND: begin
        if (pending_r == '0) begin
          state_nxt = ST_FIND;
        end else begin
          pick        = lowest_index(pending_r);
          pending_nxt = pending_r & ~vbit(pick);
          ram_raddr   = pick;
          rd_row_nxt  = pick;
          state_nxt   = ST_ABSORB;
        end
      end

      ST_ABSORB: begin
        reached_nxt = reached_r | row_new;
        pending_nxt = pending_r | row_new;
        state_nxt   = ST_EXPAND;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= VCNT_RESET;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_use_r   <= in_use_nxt;
    last_v_r   <= last_v_nxt;
    cur_v_r    <= cur_v_nxt;
    reached_r  <= reached_nxt;
    pending_r  <= pending_nxt;
    tally_r    <= tally_nxt;
    mask_r     <= mask_nxt;
    edge_a_r   <= edge_a_nxt;
    edge_b_r   <= edge_b_nxt;
    edge_set_r <= edge_set_nxt;
    rd_row_r   <= rd_row_nxt;
  end

  // The mask register is only looked at while the strobe is high; it is not
  // touched again until the next compute word is taken.
  assign out_valid             = out_valid_r;
  assign out_articulation_mask = mask_r[OUT_W-1:0];

endmodule

// ===== rtl/apf_checker.sv =====
// ----------------------------------------------------------------------------
// apf_checker
// Port-level checks on the articulation point finder, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apf_checker
  import apf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_command,
  input logic out_valid
);

  `APF_ASSERT_IMP(a_result_while_idle, out_valid, !busy, "result word shown while busy")
  `APF_ASSERT_NXT(a_write_occupies, start && !busy && in_command == CMD_WRITE_EDGE, busy, "edge write did not hold busy")
  `APF_ASSERT_NXT(a_compute_moves, start && !busy && in_command == CMD_COMPUTE, busy || out_valid, "compute word neither ran nor finished")
  `APF_ASSERT_NXT(a_no_stray_result, !busy && !start, !out_valid, "result word with no work in hand")
  `APF_ASSERT_RST(a_reset_quiet, !busy && !out_valid, "block not idle after reset")

endmodule

bind articulation_point_finder_top apf_checker u_apf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);
